/* rtl/lmdb_pkg.sv */
// shared types, constants and helpers for the label map disk brush
package lmdb_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int MEM_DEPTH  = MAX_ROWS * (1 << COL_W);
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int RAD_W      = 11;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int CRD_W      = RAD_W + 1;
    localparam int LABEL_W    = 8;
    localparam int ROOT_STEPS = RAD_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS + 1);
    localparam int COLS_RESET = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int ROWS_RESET = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    localparam logic REG_IMAGE_COLS = 1'b0;
    localparam logic REG_IMAGE_ROWS = 1'b1;

    typedef enum logic [1:0] {
        OP_STAMP = 2'd0,
        OP_CLASS = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } lmdb_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ_ISSUE,
        ST_READ_CAPTURE,
        ST_STAMP_INIT,
        ST_ROW_MUL,
        ST_ROW_ROOT_START,
        ST_ROW_ROOT,
        ST_ROW_SPAN,
        ST_CLASS_ROW,
        ST_CLASS_SPAN,
        ST_RESULT
    } lmdb_state_t;

    typedef struct packed {
        logic               re;
        logic [ADDR_W-1:0]  raddr;
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [LABEL_W-1:0] wdata;
    } lmdb_ram_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]   y;
        logic [COL_W-1:0]   x_lo;
        logic [COL_W-1:0]   x_hi;
        logic [LABEL_W-1:0] match_label;
        logic [LABEL_W-1:0] write_label;
        logic               write_all;
    } lmdb_span_cmd_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0)
            res = DIM_W'(1);
        else if (int'(v) > maxv)
            res = DIM_W'(maxv);
        return res;
    endfunction

endpackage

/* rtl/lmdb_ram.sv */
// generic simple dual-port ram with registered read
module lmdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/lmdb_isqrt.sv */
// iterative integer floor square root, one bit pair per cycle
module lmdb_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lmdb_pkg::SQ_W-1:0]     value,
    output logic                          busy,
    output logic [lmdb_pkg::RAD_W-1:0]    root
);

    logic [lmdb_pkg::SQ_W-1:0]   v_reg, v_next;
    logic [lmdb_pkg::SQ_W-1:0]   res_reg, res_next;
    logic [lmdb_pkg::SQ_W-1:0]   bit_reg, bit_next;
    logic [lmdb_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [lmdb_pkg::SQ_W:0]     trial;

    assign busy = (cnt_reg != '0);
    assign root = res_reg[lmdb_pkg::RAD_W-1:0];

    always_comb
    begin
        trial    = {1'b0, res_reg} + {1'b0, bit_reg};
        v_next   = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            v_next   = value;
            res_next = '0;
            bit_next = lmdb_pkg::SQ_W'(1) << (2 * (lmdb_pkg::RAD_W - 1));
            cnt_next = lmdb_pkg::STEP_W'(lmdb_pkg::ROOT_STEPS);
        end
        else if (busy)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = v_reg - trial[lmdb_pkg::SQ_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - lmdb_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

endmodule

/* rtl/lmdb_span.sv */
// row span walker: pipelined read-modify-write of one pixel per cycle
module lmdb_span (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  lmdb_pkg::lmdb_span_cmd_t        cmd,
    input  logic [lmdb_pkg::LABEL_W-1:0]    ram_rdata,
    output logic                            busy,
    output lmdb_pkg::lmdb_ram_req_t         req
);

    lmdb_pkg::lmdb_span_cmd_t   cmd_reg;
    logic [lmdb_pkg::COL_W-1:0] x_reg;
    logic [lmdb_pkg::COL_W-1:0] wr_x_reg;
    logic                       act_reg;
    logic                       wr_vld_reg;

    assign busy = act_reg || wr_vld_reg;

    always_comb
    begin
        req.re    = act_reg;
        req.raddr = {cmd_reg.y, x_reg};
        req.we    = wr_vld_reg && (cmd_reg.write_all || (ram_rdata == cmd_reg.match_label));
        req.waddr = {cmd_reg.y, wr_x_reg};
        req.wdata = cmd_reg.write_label;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            wr_vld_reg <= 1'b0;
        end
        else
        begin
            wr_vld_reg <= act_reg;
            if (start)
            begin
                act_reg <= 1'b1;
            end
            else if (act_reg && (x_reg == cmd_reg.x_hi))
            begin
                act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_x_reg <= x_reg;
        if (start)
        begin
            cmd_reg <= cmd;
            x_reg   <= cmd.x_lo;
        end
        else if (act_reg)
        begin
            x_reg <= x_reg + lmdb_pkg::COL_W'(1);
        end
    end

endmodule

/* rtl/label_map_disk_brush.sv */
// top level: label map with disk brush, class clear, full clear and pixel read
// One item is taken at a time and gives one result. A stamp sets up the disk and then,
// for each covered row, squares the row offset, runs an 11-step floor root and walks the
// clipped span; clear class walks every image row across its full width; a pixel read
// reads the addressed entry; clear all writes every entry of the 1,048,576-entry map,
// one per cycle, and the same pass runs after reset, during which no item is taken
// (register writes still are). The pace is set by the single label memory, which gives
// one pixel read-modify-write per cycle, and by the per-row root unit.
module label_map_disk_brush (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[9:0], pos_y[19:10], disk_radius[30:20], base_label[38:31],
    // target_label[46:39], replace_all[47]
    input  logic [47:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_label[7:0]
    output logic [7:0]  m_axis_tdata,
    // out_of_range[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = lmdb_pkg::CRD_W;

    lmdb_pkg::lmdb_state_t state_reg, state_next;

    logic [lmdb_pkg::DIM_W-1:0]   cols_reg, rows_reg;
    logic                         init_reg;
    logic [lmdb_pkg::ADDR_W-1:0]  sweep_addr_reg;
    logic                         sweep_last;

    lmdb_pkg::lmdb_op_t           in_op;
    logic [lmdb_pkg::POS_W-1:0]   in_x, in_y;
    logic                         acc;
    logic                         in_oor;

    logic [lmdb_pkg::POS_W-1:0]   px_reg, py_reg;
    logic [lmdb_pkg::RAD_W-1:0]   rad_reg;
    logic [lmdb_pkg::LABEL_W-1:0] base_reg, target_reg;
    logic                         all_reg;

    logic [CW-1:0]                y_reg, y_hi_reg;
    logic [lmdb_pkg::SQ_W-1:0]    rsq_reg, adysq_reg;
    logic [CW-1:0]                cx, cy, r12, y_sum, x_sum, h12, cols12, rows12;
    logic [CW-1:0]                y_lo, y_hi, x_lo, x_hi, ady_full;
    logic [lmdb_pkg::RAD_W-1:0]   ady;

    logic [lmdb_pkg::LABEL_W-1:0] res_label_reg;
    logic                         res_oor_reg;
    logic                         out_vld_reg;
    logic [lmdb_pkg::LABEL_W-1:0] out_label_reg;
    logic                         out_oor_reg;
    logic                         out_load;

    logic                         root_start, root_busy;
    logic [lmdb_pkg::RAD_W-1:0]   root;
    logic                         span_start, span_busy;
    lmdb_pkg::lmdb_span_cmd_t     span_cmd;
    lmdb_pkg::lmdb_ram_req_t      span_req, ram_req;
    logic [lmdb_pkg::LABEL_W-1:0] ram_rdata;

    logic                         cfg_we;

    // input fields
    assign in_op  = lmdb_pkg::lmdb_op_t'(s_axis_tuser);
    assign in_x   = s_axis_tdata[9:0];
    assign in_y   = s_axis_tdata[19:10];
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign in_oor = ({1'b0, in_x} >= cols_reg) || ({1'b0, in_y} >= rows_reg);

    assign s_axis_tready = (state_reg == lmdb_pkg::ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_label_reg;
    assign m_axis_tuser  = out_oor_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            lmdb_pkg::REG_IMAGE_COLS: prdata = 32'(cols_reg);
            lmdb_pkg::REG_IMAGE_ROWS: prdata = 32'(rows_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= lmdb_pkg::DIM_W'(lmdb_pkg::COLS_RESET);
            rows_reg <= lmdb_pkg::DIM_W'(lmdb_pkg::ROWS_RESET);
        end
        else if (cfg_we)
        begin
            if (paddr[2] == lmdb_pkg::REG_IMAGE_COLS)
            begin
                cols_reg <= lmdb_pkg::clamp_dim(pwdata[lmdb_pkg::DIM_W-1:0], lmdb_pkg::MAX_COLS);
            end
            else
            begin
                rows_reg <= lmdb_pkg::clamp_dim(pwdata[lmdb_pkg::DIM_W-1:0], lmdb_pkg::MAX_ROWS);
            end
        end
    end

    // disk geometry
    always_comb
    begin
        cx       = CW'(px_reg);
        cy       = CW'(py_reg);
        r12      = CW'(rad_reg);
        h12      = CW'(root);
        cols12   = CW'(cols_reg);
        rows12   = CW'(rows_reg);
        y_sum    = cy + r12;
        y_lo     = (cy < r12) ? '0 : cy - r12;
        y_hi     = (y_sum >= rows12) ? rows12 - CW'(1) : y_sum;
        x_sum    = cx + h12;
        x_lo     = (cx < h12) ? '0 : cx - h12;
        x_hi     = (x_sum >= cols12) ? cols12 - CW'(1) : x_sum;
        ady_full = (y_reg >= cy) ? y_reg - cy : cy - y_reg;
        ady      = ady_full[lmdb_pkg::RAD_W-1:0];
    end

    always_comb
    begin
        span_cmd.y = lmdb_pkg::ROW_W'(y_reg);
        if (state_reg == lmdb_pkg::ST_CLASS_ROW)
        begin
            span_cmd.x_lo        = '0;
            span_cmd.x_hi        = lmdb_pkg::COL_W'(cols12 - CW'(1));
            span_cmd.match_label = base_reg;
            span_cmd.write_label = '0;
            span_cmd.write_all   = 1'b0;
        end
        else
        begin
            span_cmd.x_lo        = lmdb_pkg::COL_W'(x_lo);
            span_cmd.x_hi        = lmdb_pkg::COL_W'(x_hi);
            span_cmd.match_label = base_reg;
            span_cmd.write_label = target_reg;
            span_cmd.write_all   = all_reg;
        end
    end

    assign sweep_last = (sweep_addr_reg == lmdb_pkg::ADDR_W'(lmdb_pkg::MEM_DEPTH - 1));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmdb_pkg::ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        root_start = 1'b0;
        span_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            lmdb_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    case (in_op)
                        lmdb_pkg::OP_STAMP:
                            state_next = in_oor ? lmdb_pkg::ST_RESULT : lmdb_pkg::ST_STAMP_INIT;
                        lmdb_pkg::OP_READ:
                            state_next = in_oor ? lmdb_pkg::ST_RESULT : lmdb_pkg::ST_READ_ISSUE;
                        lmdb_pkg::OP_CLASS:
                            state_next = lmdb_pkg::ST_CLASS_ROW;
                        default:
                            state_next = lmdb_pkg::ST_SWEEP;
                    endcase
                end
            end
            lmdb_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = init_reg ? lmdb_pkg::ST_IDLE : lmdb_pkg::ST_RESULT;
                end
            end
            lmdb_pkg::ST_READ_ISSUE:
                state_next = lmdb_pkg::ST_READ_CAPTURE;
            lmdb_pkg::ST_READ_CAPTURE:
                state_next = lmdb_pkg::ST_RESULT;
            lmdb_pkg::ST_STAMP_INIT:
                state_next = lmdb_pkg::ST_ROW_MUL;
            lmdb_pkg::ST_ROW_MUL:
                state_next = lmdb_pkg::ST_ROW_ROOT_START;
            lmdb_pkg::ST_ROW_ROOT_START:
            begin
                root_start = 1'b1;
                state_next = lmdb_pkg::ST_ROW_ROOT;
            end
            lmdb_pkg::ST_ROW_ROOT:
            begin
                if (!root_busy)
                begin
                    span_start = 1'b1;
                    state_next = lmdb_pkg::ST_ROW_SPAN;
                end
            end
            lmdb_pkg::ST_ROW_SPAN:
            begin
                if (!span_busy)
                begin
                    state_next = (y_reg == y_hi_reg) ? lmdb_pkg::ST_RESULT : lmdb_pkg::ST_ROW_MUL;
                end
            end
            lmdb_pkg::ST_CLASS_ROW:
            begin
                span_start = 1'b1;
                state_next = lmdb_pkg::ST_CLASS_SPAN;
            end
            lmdb_pkg::ST_CLASS_SPAN:
            begin
                if (!span_busy)
                begin
                    state_next = (y_reg == rows12 - CW'(1)) ? lmdb_pkg::ST_RESULT
                                                            : lmdb_pkg::ST_CLASS_ROW;
                end
            end
            lmdb_pkg::ST_RESULT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = lmdb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lmdb_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg       <= 1'b1;
            sweep_addr_reg <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == lmdb_pkg::ST_SWEEP)
            begin
                sweep_addr_reg <= sweep_last ? '0 : sweep_addr_reg + lmdb_pkg::ADDR_W'(1);
                if (sweep_last)
                begin
                    init_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            px_reg        <= in_x;
            py_reg        <= in_y;
            rad_reg       <= s_axis_tdata[30:20];
            base_reg      <= s_axis_tdata[38:31];
            target_reg    <= s_axis_tdata[46:39];
            all_reg       <= s_axis_tdata[47];
            y_reg         <= '0;
            res_label_reg <= '0;
            res_oor_reg   <= in_oor && ((in_op == lmdb_pkg::OP_STAMP) || (in_op == lmdb_pkg::OP_READ));
        end
        if (state_reg == lmdb_pkg::ST_STAMP_INIT)
        begin
            y_reg    <= y_lo;
            y_hi_reg <= y_hi;
            rsq_reg  <= lmdb_pkg::SQ_W'(rad_reg) * lmdb_pkg::SQ_W'(rad_reg);
        end
        if (state_reg == lmdb_pkg::ST_ROW_MUL)
        begin
            adysq_reg <= lmdb_pkg::SQ_W'(ady) * lmdb_pkg::SQ_W'(ady);
        end
        if (((state_reg == lmdb_pkg::ST_ROW_SPAN) || (state_reg == lmdb_pkg::ST_CLASS_SPAN))
            && !span_busy)
        begin
            y_reg <= y_reg + CW'(1);
        end
        if (state_reg == lmdb_pkg::ST_READ_CAPTURE)
        begin
            res_label_reg <= ram_rdata;
        end
        if (out_load)
        begin
            out_label_reg <= res_label_reg;
            out_oor_reg   <= res_oor_reg;
        end
    end

    // memory port selection
    always_comb
    begin
        ram_req = span_req;
        case (state_reg)
            lmdb_pkg::ST_SWEEP:
            begin
                ram_req.re    = 1'b0;
                ram_req.we    = 1'b1;
                ram_req.waddr = sweep_addr_reg;
                ram_req.wdata = '0;
            end
            lmdb_pkg::ST_READ_ISSUE:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = {lmdb_pkg::ROW_W'(py_reg), lmdb_pkg::COL_W'(px_reg)};
                ram_req.we    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    lmdb_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (rsq_reg - adysq_reg),
        .busy  (root_busy),
        .root  (root)
    );

    lmdb_span u_span (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (span_start),
        .cmd       (span_cmd),
        .ram_rdata (ram_rdata),
        .busy      (span_busy),
        .req       (span_req)
    );

    lmdb_ram #(
        .WIDTH (lmdb_pkg::LABEL_W),
        .DEPTH (lmdb_pkg::MEM_DEPTH)
    ) u_label_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("label memory read and write hit the same entry");

    a_span_in_span_state: assert property (@(posedge clk) disable iff (!rst_n)
        span_busy |-> ((state_reg == lmdb_pkg::ST_ROW_SPAN)
                       || (state_reg == lmdb_pkg::ST_CLASS_SPAN)))
        else $error("span walker busy outside a span state");

    a_root_span_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(root_busy && span_busy))
        else $error("root unit and span walker busy together");

    a_oor_label_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("out of range result carries a label");

endmodule
